// ----- src/serial_clock_led_matrix_driver_unit_macros.svh -----
// Assertion macros for the serial clock LED matrix driver.
`ifndef SERIAL_CLOCK_LED_MATRIX_DRIVER_UNIT_MACROS_SVH
`define SERIAL_CLOCK_LED_MATRIX_DRIVER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SLMD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SLMD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/slmd_pkg.sv -----
// Shared types, constants and glyph functions for the LED matrix clock driver.
package slmd_pkg;

  localparam int PANEL_ROWS_DEF     = 16;
  localparam int MESSAGE_LENGTH_DEF = 10;
  localparam int PANEL_COLUMNS      = 32;
  localparam int GLYPH_ROWS         = 8;
  localparam int GLYPH_ROW_W        = $clog2(GLYPH_ROWS);
  localparam int TIME_DIGITS        = 6;
  localparam int TIME_FIRST         = 4;
  localparam int IDX_W              = 4;
  localparam int OFFSET_W           = 5;
  localparam int CODE_W             = 4;
  localparam int DAY_HOURS          = 24;
  localparam int HOUR_W             = 13;

  localparam logic [7:0]          START_CHAR        = 8'h52;
  localparam logic [7:0]          CHAR_ZERO         = 8'h30;
  localparam logic [7:0]          CHAR_NINE         = 8'h39;
  localparam logic [5:0]          COLOUR_UPPER      = 6'd33;
  localparam logic [5:0]          COLOUR_LOWER      = 6'd50;
  localparam logic [OFFSET_W-1:0] HOUR_OFFSET_RESET = 5'd5;
  localparam logic [CODE_W-1:0]   CODE_BLANK        = 4'hA;
  localparam logic [CODE_W-1:0]   CODE_ONE          = 4'h1;

  localparam logic [31:0] GLYPH_TABLE [10] = '{
    32'h06999996, 32'h0E444464, 32'h0F124896, 32'h0698E896, 32'h0444F555,
    32'h0698611F, 32'h06997196, 32'h0112488F, 32'h06996996, 32'h0698E996
  };

  localparam int DIGIT_COL [TIME_DIGITS] = '{0, 5, 12, 17, 23, 28};

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [3:0]               row_address;
    logic [PANEL_COLUMNS-1:0] row_bits;
    logic [5:0]               colour_pins;
    logic                     time_updated;
  } out_t;

  // One glyph code per display digit; CODE_BLANK shows nothing.
  typedef logic [TIME_DIGITS-1:0][CODE_W-1:0] codes_t;

  typedef struct packed {
    logic   start;
    codes_t codes;
  } build_t;

  function automatic logic [CODE_W-1:0] char_code(input logic [7:0] c);
    logic [7:0] d;
    d = c - CHAR_ZERO;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return d[CODE_W-1:0];
    return CODE_BLANK;
  endfunction

  function automatic logic [3:0] glyph_nibble(input logic [CODE_W-1:0] code,
                                              input logic [GLYPH_ROW_W-1:0] row);
    logic [31:0] g;
    g = (code <= 4'd9) ? GLYPH_TABLE[code] : 32'h0;
    return g[{row, 2'b00} +: 4];
  endfunction

  function automatic logic [PANEL_COLUMNS-1:0] row_word(input codes_t codes,
                                                        input logic [GLYPH_ROW_W-1:0] row);
    logic [PANEL_COLUMNS-1:0] w;
    w = '0;
    for (int k = 0; k < TIME_DIGITS; k++) begin
      w = w | (PANEL_COLUMNS'(glyph_nibble(codes[k], row)) << DIGIT_COL[k]);
    end
    return w;
  endfunction

endpackage

// ----- src/slmd_row_store.sv -----
// Row word memory with its rebuild sweep and registered read port.
module slmd_row_store (
  input  logic                                 clk,
  input  logic                                 rst,
  input  slmd_pkg::build_t                     build,
  input  logic                                 rd_en,
  input  logic [slmd_pkg::GLYPH_ROW_W-1:0]     rd_addr,
  output logic [slmd_pkg::PANEL_COLUMNS-1:0]   rd_data,
  output logic                                 busy
);
  import slmd_pkg::*;

  logic [PANEL_COLUMNS-1:0] mem [GLYPH_ROWS];
  logic [GLYPH_ROWS-1:0]    row_valid;
  logic [GLYPH_ROW_W-1:0]   sweep_row;
  codes_t                   codes;
  logic [PANEL_COLUMNS-1:0] rd_q;
  logic                     rd_ok;

  // sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      sweep_row <= '0;
      row_valid <= '0;
    end else if (build.start) begin
      busy      <= 1'b1;
      sweep_row <= '0;
    end else if (busy) begin
      row_valid[sweep_row] <= 1'b1;
      sweep_row            <= sweep_row + 1'b1;
      if (sweep_row == GLYPH_ROW_W'(GLYPH_ROWS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (build.start) begin
      codes <= build.codes;
    end
  end

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[sweep_row] <= row_word(codes, sweep_row);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      rd_ok <= row_valid[rd_addr];
    end
  end

  // rows never built read as blank
  assign rd_data = rd_ok ? rd_q : '0;

endmodule

// ----- src/serial_clock_led_matrix_driver_unit.sv -----
// Top level of the serial clock LED matrix driver: receive framing, hour fold, scan output.
// Takes one word per cycle while item_ready is high: either a received serial byte or a scan
// tick. Every word gives exactly one result word, through the synchronous read of the row
// memory, held in stage 2 beside the word, and then the output queue, which holds up to
// three results so input keeps flowing while the far side stalls, until the queue is full.
// A byte that completes a time message ('R' plus MESSAGE_LENGTH-1 more bytes, HHMMSS
// in bytes 4..9) starts a rebuild of the eight row words: the row memory has one
// write port, so the rebuild writes the rows one at a time, and item_ready stays low while it runs.
// Scan ticks return the next panel row's 32 column bits, with rows 8..15 repeating
// rows 0..7, and colour mask 33 (upper half) or 50 (lower half). hour_offset (reset 5)
// is applied when the message completes.
// The row memory reads as blank after reset; there is no clearing pass.
module serial_clock_led_matrix_driver_unit #(
  parameter int PANEL_ROWS     = slmd_pkg::PANEL_ROWS_DEF,
  parameter int MESSAGE_LENGTH = slmd_pkg::MESSAGE_LENGTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [slmd_pkg::OFFSET_W-1:0] cfg_wdata,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  slmd_pkg::in_t                 item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output slmd_pkg::out_t                result
);
  import slmd_pkg::*;
  `include "serial_clock_led_matrix_driver_unit_macros.svh"

  localparam int               ROW_W      = $clog2(PANEL_ROWS);
  localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(PANEL_ROWS - 1);
  localparam logic [ROW_W-1:0] ROW_HALF   = ROW_W'(PANEL_ROWS / 2);
  localparam logic [IDX_W-1:0] MSG_LAST   = IDX_W'(MESSAGE_LENGTH - 1);
  localparam logic [IDX_W-1:0] IDX_HOUR_T = IDX_W'(TIME_FIRST);
  localparam logic [IDX_W-1:0] IDX_HOUR_O = IDX_W'(TIME_FIRST + 1);
  localparam logic [IDX_W-1:0] IDX_TAIL   = IDX_W'(TIME_FIRST + 2);
  localparam logic [IDX_W-1:0] IDX_END    = IDX_W'(TIME_FIRST + TIME_DIGITS - 1);
  localparam int               FIFO_DEPTH = 3;
  localparam int               TAIL_N     = TIME_DIGITS - 2;

  // ---------------------------------------------------------------- config
  logic [OFFSET_W-1:0] hour_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_offset <= HOUR_OFFSET_RESET;
    end else if (cfg_we) begin
      hour_offset <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------- accept
  logic accept;
  logic is_scan;
  logic is_byte;
  logic busy;

  assign accept  = item_valid & item_ready;
  assign is_scan = accept & item.operation;
  assign is_byte = accept & ~item.operation;

  // ---------------------------------------------------------------- receive
  logic [IDX_W-1:0]         receive_index;
  logic [7:0]               hour_tens_char;   // raw byte 4
  logic signed [HOUR_W-1:0] hour_part;        // 10*(c4-48) + (c5-48)
  logic [CODE_W-1:0]        tail_codes [TAIL_N];
  logic                     in_message;
  logic                     complete;
  logic [IDX_W-1:0]         tail_sel;
  logic signed [HOUR_W-1:0] tens_s;
  logic signed [HOUR_W-1:0] ones_s;
  logic signed [HOUR_W-1:0] hour_part_next;

  assign in_message = (receive_index != '0) || (item.rx_byte == START_CHAR);
  assign complete   = is_byte && in_message && (receive_index == MSG_LAST);
  assign tail_sel   = receive_index - IDX_TAIL;

  assign tens_s         = signed'({5'b0, hour_tens_char});
  assign ones_s         = signed'({5'b0, item.rx_byte});
  assign hour_part_next = (tens_s <<< 3) + (tens_s <<< 1) + ones_s
                          - HOUR_W'(11 * 48);

  always_ff @(posedge clk) begin
    if (rst) begin
      receive_index <= '0;
    end else if (is_byte && in_message) begin
      if (receive_index == MSG_LAST) begin
        receive_index <= '0;
      end else begin
        receive_index <= receive_index + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_byte && in_message) begin
      if (receive_index == IDX_HOUR_T) begin
        hour_tens_char <= item.rx_byte;
      end
      if (receive_index == IDX_HOUR_O) begin
        hour_part <= hour_part_next;
      end
      if (receive_index >= IDX_TAIL && receive_index <= IDX_END) begin
        tail_codes[tail_sel[1:0]] <= char_code(item.rx_byte);
      end
    end
  end

  // ---------------------------------------------------------------- hour fold
  // Offset added, then folded: >24 drop a day, >12 drop half a day, >=10 split tens.
  logic signed [HOUR_W-1:0] h0, h1, h2, h3;
  logic                     hour_tens;
  build_t                   build;

  always_comb begin
    h0        = hour_part + signed'({8'b0, hour_offset});
    h1        = (h0 >= HOUR_W'(DAY_HOURS + 1))     ? h0 - HOUR_W'(DAY_HOURS)     : h0;
    h2        = (h1 >= HOUR_W'(DAY_HOURS / 2 + 1)) ? h1 - HOUR_W'(DAY_HOURS / 2) : h1;
    hour_tens = (h2 >= HOUR_W'(10));
    h3        = hour_tens ? h2 - HOUR_W'(10) : h2;

    build.start    = complete;
    build.codes[0] = hour_tens ? CODE_ONE : CODE_BLANK;
    build.codes[1] = (h3 >= HOUR_W'(0) && h3 <= HOUR_W'(9)) ? h3[CODE_W-1:0] : CODE_BLANK;
    for (int k = 0; k < TAIL_N - 1; k++) begin
      build.codes[k + 2] = tail_codes[k];
    end
    // last seconds digit arrives with the completing byte when the message is minimal
    build.codes[TIME_DIGITS-1] = (receive_index == IDX_END) ? char_code(item.rx_byte)
                                                            : tail_codes[TAIL_N-1];
  end

  // ---------------------------------------------------------------- scan
  logic [ROW_W-1:0] scan_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row <= '0;
    end else if (is_scan) begin
      scan_row <= (scan_row == ROW_LAST) ? '0 : scan_row + 1'b1;
    end
  end

  logic [PANEL_COLUMNS-1:0] rd_data;

  slmd_row_store u_rows (
    .clk     (clk),
    .rst     (rst),
    .build   (build),
    .rd_en   (is_scan),
    .rd_addr (GLYPH_ROW_W'(scan_row)),
    .rd_data (rd_data),
    .busy    (busy)
  );

  // ---------------------------------------------------------------- stage 2
  // Lines up with the memory read data.
  logic       s2_valid;
  logic       s2_scan;
  logic       s2_upd;
  logic [3:0] s2_addr;
  logic [5:0] s2_colour;
  out_t       s2_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_scan   <= item.operation;
      s2_upd    <= complete;
      s2_addr   <= 4'(scan_row);
      s2_colour <= (scan_row < ROW_HALF) ? COLOUR_UPPER : COLOUR_LOWER;
    end
  end

  always_comb begin
    s2_out = '0;
    if (s2_scan) begin
      s2_out.row_address = s2_addr;
      s2_out.row_bits    = rd_data;
      s2_out.colour_pins = s2_colour;
    end else begin
      s2_out.time_updated = s2_upd;
    end
  end

  // ---------------------------------------------------------------- output queue
  out_t       fifo_mem [FIFO_DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [1:0] fifo_cnt;
  logic       pop;

  assign pop          = result_valid & result_ready;
  assign result_valid = (fifo_cnt != '0);
  assign result       = fifo_mem[rd_ptr];
  // room for the word in stage 2 plus one more
  assign item_ready   = !busy && (({1'b0, fifo_cnt} + {2'b0, s2_valid}) < 3'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (s2_valid) begin
        wr_ptr <= (wr_ptr == 2'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == 2'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fifo_cnt <= fifo_cnt + 2'(s2_valid) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      fifo_mem[wr_ptr] <= s2_out;
    end
  end

  // ---------------------------------------------------------------- checks
  `SLMD_ASSERT_IMP(a_queue_no_overflow, s2_valid && fifo_cnt == 2'(FIFO_DEPTH), pop, "output queue overflow")
  `SLMD_ASSERT_NXT(a_update_starts_build, complete, busy && !item_ready, "row rebuild did not start")
  `SLMD_ASSERT_NXT(a_scan_wraps, is_scan && scan_row == ROW_LAST, scan_row == '0, "scan row did not wrap")

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the serial clock LED matrix driver: directed table, then random traffic.
module tb;
  import slmd_pkg::*;

  // Word kinds on the input channel.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  localparam int SCAN_ROWS     = 16;   // panel rows, upper and lower half
  localparam int FACE_ROWS     = 8;    // distinct row words, repeated for the lower half
  localparam int MSG_LEN       = 10;   // 'R' plus nine bytes
  localparam int TIME_AT       = 4;    // first HHMMSS byte within a message
  localparam int FACE_DIGITS   = 6;
  localparam int SETTLE_CYCLES = 16;   // covers the row rebuild plus output pipe
  localparam int CHUNK_WORDS   = 100;  // counted words per hour offset setting
  localparam int CHUNKS        = 9;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  // 4x8 font, one nibble per glyph row, row 0 in the low nibble.
  localparam logic [31:0] DIGIT_FONT [10] = '{
    32'h06999996, 32'h0E444464, 32'h0F124896, 32'h0698E896, 32'h0444F555,
    32'h0698611F, 32'h06997196, 32'h0112488F, 32'h06996996, 32'h0698E996
  };
  // Left column of each digit: H H : M M : S S
  localparam int DIGIT_X [FACE_DIGITS] = '{0, 5, 12, 17, 23, 28};

  // Results that can be read straight off the spec.
  localparam out_t NO_RESULT       = '0;
  localparam out_t MSG_DONE        = '{row_address: 4'd0, row_bits: 32'd0,
                                       colour_pins: 6'd0, time_updated: 1'b1};
  localparam out_t FIRST_ROW_BLANK = '{row_address: 4'd0, row_bits: 32'd0,
                                       colour_pins: COLOUR_UPPER, time_updated: 1'b0};

  // One line of the directed table: either an offset write or a word to send.
  typedef struct packed {
    bit                  is_cfg;
    logic [OFFSET_W-1:0] cfg_val;
    in_t                 word;
    bit                  typed;   // use want as is instead of the display model
    out_t                want;
  } stim_row_t;

  // DUT ports; every input known from time zero.
  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                cfg_we       = 1'b0;
  logic [OFFSET_W-1:0] cfg_wdata    = '0;
  logic                item_valid   = 1'b0;
  logic                item_ready;
  in_t                 item         = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  out_t                result;

  // Display model state.
  logic [OFFSET_W-1:0] hour_shift;
  int                  msg_pos;
  logic [7:0]          time_text [FACE_DIGITS];
  logic [31:0]         face_rows [FACE_ROWS];
  int                  next_scan_row;

  out_t due_words [$];     // results owed by the DUT, oldest first
  in_t  burst_words [$];   // random words waiting to go out
  out_t head_word;

  int send_idle_pct = 34;
  int recv_idle_pct = 66;
  int mismatches    = 0;
  int messages_seen = 0;
  int scans_seen    = 0;
  int settings_seen = 0;
  int words_counted = 0;

  serial_clock_led_matrix_driver_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  function automatic logic [31:0] char_glyph(input logic [7:0] c);
    if (c >= ASCII_ZERO && c <= ASCII_NINE) return DIGIT_FONT[c - ASCII_ZERO];
    return 32'h0;
  endfunction

  // Fold the hour into 12-hour form and repack all eight row words.
  task automatic redraw_face();
    logic [31:0] glyph [FACE_DIGITS];
    logic [31:0] w;
    int          h;
    // Non-digit hour bytes still go through the arithmetic, so h can be far out of range.
    h = (int'(time_text[0]) - int'(ASCII_ZERO)) * 10
        + (int'(time_text[1]) - int'(ASCII_ZERO)) + int'(hour_shift);
    if (h >= 25) h -= 24;
    if (h >= 13) h -= 12;
    if (h >= 10) begin
      h -= 10;
      glyph[0] = DIGIT_FONT[1];
    end else begin
      glyph[0] = 32'h0;   // blank tens digit
    end
    glyph[1] = (h >= 0 && h <= 9) ? DIGIT_FONT[h] : 32'h0;
    for (int k = 2; k < FACE_DIGITS; k++) glyph[k] = char_glyph(time_text[k]);
    for (int r = 0; r < FACE_ROWS; r++) begin
      w = '0;
      for (int k = 0; k < FACE_DIGITS; k++)
        w |= ((glyph[k] >> (4 * r)) & 32'hF) << DIGIT_X[k];
      face_rows[r] = w;
    end
  endtask

  // Advance the display model by one accepted word and give its result.
  task automatic step_display(input in_t w, output out_t res);
    res = '0;
    if (w.operation == OP_SCAN) begin
      res.row_address = 4'(next_scan_row);
      res.row_bits    = face_rows[next_scan_row % FACE_ROWS];
      res.colour_pins = (next_scan_row < SCAN_ROWS / 2) ? COLOUR_UPPER : COLOUR_LOWER;
      next_scan_row   = (next_scan_row + 1) % SCAN_ROWS;
      scans_seen++;
    end else if (msg_pos != 0 || w.rx_byte == START_CHAR) begin
      // Anything other than 'R' between messages is dropped, with an all-zero result.
      if (msg_pos >= TIME_AT && msg_pos < TIME_AT + FACE_DIGITS)
        time_text[msg_pos - TIME_AT] = w.rx_byte;
      msg_pos++;
      if (msg_pos >= MSG_LEN) begin
        msg_pos = 0;
        redraw_face();
        res.time_updated = 1'b1;
        messages_seen++;
      end
    end
  endtask

  // Present one word, hold it until accepted, then book its result.
  // Valid is only dropped when a gap is taken, so it never toggles within a step.
  task automatic send_word(input in_t w, input bit typed, input out_t typed_res,
                           output bit counted);
    out_t res;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    item       <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    counted = !(w.operation == OP_BYTE && msg_pos == 0 && w.rx_byte != START_CHAR);
    if (counted) words_counted++;
    step_display(w, res);
    due_words.push_back(typed ? typed_res : res);
  endtask

  // Sender holds off until every booked result is back.
  task automatic wait_results_clear();
    item_valid <= 1'b0;
    do @(posedge clk); while (due_words.size() != 0);
  endtask

  // Offset changes only with the unit idle; a rebuild may outlast its result word.
  task automatic set_hour_shift(input logic [OFFSET_W-1:0] v);
    wait_results_clear();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    hour_shift  = v;
    settings_seen++;
  endtask

  // Mostly plausible HHMMSS digits, with the odd arbitrary byte.
  function automatic logic [7:0] random_time_char(input int pos);
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    case (pos)
      0:       return ASCII_ZERO + 8'($urandom_range(0, 2));
      2, 4:    return ASCII_ZERO + 8'($urandom_range(0, 5));
      default: return ASCII_ZERO + 8'($urandom_range(0, 9));
    endcase
  endfunction

  // Queue one random burst: a framed message with scans mixed in, a scan run,
  // line noise, or a message cut short (it swallows whatever follows).
  task automatic build_burst();
    int         kind;
    logic [7:0] b;
    kind = $urandom_range(0, 15);
    if (kind < 10) begin
      for (int i = 0; i < MSG_LEN; i++) begin
        if ($urandom_range(0, 3) == 0)
          burst_words.push_back(in_t'{OP_SCAN, 8'($urandom_range(0, 255))});
        if (i == 0) b = START_CHAR;
        else if (i < TIME_AT) b = 8'($urandom_range(0, 255));
        else b = random_time_char(i - TIME_AT);
        burst_words.push_back(in_t'{OP_BYTE, b});
      end
    end else if (kind < 13) begin
      repeat ($urandom_range(1, 20))
        burst_words.push_back(in_t'{OP_SCAN, 8'($urandom_range(0, 255))});
    end else if (kind == 13) begin
      repeat ($urandom_range(1, 4))
        burst_words.push_back(in_t'{OP_BYTE, 8'($urandom_range(0, 255))});
    end else if (kind == 14) begin
      burst_words.push_back(in_t'{OP_BYTE, START_CHAR});
      repeat ($urandom_range(1, 8))
        burst_words.push_back(in_t'{OP_BYTE, 8'($urandom_range(0, 255))});
    end else begin
      // Long scan run, enough to wrap through both panel halves.
      repeat ($urandom_range(16, 40))
        burst_words.push_back(in_t'{OP_SCAN, 8'($urandom_range(0, 255))});
    end
  endtask

  task automatic run_chunk(input int quota);
    int sent;
    bit counted;
    sent = 0;
    while (sent < quota) begin
      build_burst();
      while (burst_words.size() != 0) begin
        send_word(burst_words.pop_front(), 1'b0, NO_RESULT, counted);
        if (counted) sent++;
      end
      if ($urandom_range(0, 49) == 0) wait_results_clear();
    end
  endtask

  function automatic stim_row_t dir_word(input logic op, input logic [7:0] b,
                                         input bit typed, input out_t want);
    stim_row_t s;
    s       = '0;
    s.word  = in_t'{op, b};
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  function automatic stim_row_t dir_cfg(input logic [OFFSET_W-1:0] v);
    stim_row_t s;
    s         = '0;
    s.is_cfg  = 1'b1;
    s.cfg_val = v;
    return s;
  endfunction

  // Result checker: every delivered result against the oldest booked result.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (due_words.size() == 0) begin
        flag_mismatch("result with nothing owed, row_bits", result.row_bits, 32'h0);
      end else begin
        head_word = due_words.pop_front();
        if (result.row_address !== head_word.row_address)
          flag_mismatch("row_address", 32'(result.row_address),
                        32'(head_word.row_address));
        if (result.row_bits !== head_word.row_bits)
          flag_mismatch("row_bits", result.row_bits, head_word.row_bits);
        if (result.colour_pins !== head_word.colour_pins)
          flag_mismatch("colour_pins", 32'(result.colour_pins),
                        32'(head_word.colour_pins));
        if (result.time_updated !== head_word.time_updated)
          flag_mismatch("time_updated", 32'(result.time_updated),
                        32'(head_word.time_updated));
      end
    end
  end

  initial begin
    stim_row_t  steps [$];
    bit         counted;
    logic [7:0] msg_a [MSG_LEN];
    logic [7:0] msg_b [MSG_LEN];

    // Reset offset of 5 applies here; 'R' inside a message is plain data,
    // and the seconds tens byte is not a digit.
    msg_a = '{START_CHAR, 8'hFF, 8'h00, START_CHAR,
              "2", "3", "5", "9", "x", "0"};
    // All-zero time with offset 23 folds to 11: tens '1' shown.
    msg_b = '{START_CHAR, "A", "B", "C",
              "0", "0", "0", "0", "0", "0"};

    hour_shift    = HOUR_OFFSET_RESET;
    msg_pos       = 0;
    next_scan_row = 0;
    foreach (time_text[i]) time_text[i] = '0;
    foreach (face_rows[i]) face_rows[i] = '0;

    // Directed table.
    steps.push_back(dir_word(OP_SCAN, 8'h00, 1'b1, FIRST_ROW_BLANK));  // blank after reset
    steps.push_back(dir_word(OP_BYTE, 8'h00, 1'b1, NO_RESULT));       // dropped, not 'R'
    steps.push_back(dir_word(OP_BYTE, 8'hFF, 1'b1, NO_RESULT));
    for (int i = 0; i < MSG_LEN; i++)
      steps.push_back(dir_word(OP_BYTE, msg_a[i], 1'b1,
                               (i == MSG_LEN - 1) ? MSG_DONE : NO_RESULT));
    steps.push_back(dir_word(OP_SCAN, 8'hFF, 1'b0, NO_RESULT));
    steps.push_back(dir_cfg(5'd23));
    for (int i = 0; i < MSG_LEN; i++)
      steps.push_back(dir_word(OP_BYTE, msg_b[i], 1'b1,
                               (i == MSG_LEN - 1) ? MSG_DONE : NO_RESULT));
    steps.push_back(dir_word(OP_SCAN, 8'h5A, 1'b0, NO_RESULT));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[i]) begin
      if (steps[i].is_cfg) set_hour_shift(steps[i].cfg_val);
      else send_word(steps[i].word, steps[i].typed, steps[i].want, counted);
    end

    // Random part: three pacing profiles, new hour offset before each chunk.
    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      if (chunk == 3) begin
        send_idle_pct = 66;
        recv_idle_pct = 34;
      end else if (chunk == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (chunk == 0) set_hour_shift(5'd0);
      else if (chunk == 4) set_hour_shift(5'd23);
      else set_hour_shift(5'($urandom_range(0, 23)));
      run_chunk(CHUNK_WORDS);
    end

    wait_results_clear();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_words.size() != 0)
      flag_mismatch("results never delivered", due_words.size(), 32'h0);

    $display("covered %0d words: %0d time messages rebuilt, %0d scan ticks",
             words_counted, messages_seen, scans_seen);
    $display("hour offset set %0d times, three sender/receiver pacing profiles",
             settings_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
